// ----- rtl/core/epx3x_pkg.sv -----
package epx3x_pkg;

  // Default geometry and pixel size.
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 24;

  // Register port and fixed field widths, and the height bound.
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int COORD_W    = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int SUB_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SUB_W-1:0] SUB_TOP    = SUB_W'(0);
  localparam logic [SUB_W-1:0] SUB_CENTRE = SUB_W'(1);
  localparam logic [SUB_W-1:0] SUB_BOTTOM = SUB_W'(2);

  // Blocks released by one source pixel; they are delivered from the last member upward.
  typedef struct packed {
    logic frame_end;  // final block of the frame is among them
    logic last_end;   // block (last column, current row)
    logic last_x;     // block (column - 1, current row)
    logic mid_end;    // block (last column, row above)
    logic mid_x;      // block (column - 1, row above)
  } job_ctl_t;

endpackage

// ----- rtl/core/epx3x_line_mem.sv -----
module epx3x_line_mem #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/epx3x_emit.sv -----
module epx3x_emit #(
  parameter int PIXEL_BITS = 24,
  parameter int COL_W      = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_load,
  input  epx3x_pkg::job_ctl_t            job_ctl,
  input  logic [COL_W-1:0]               job_bx_mid,
  input  logic [COL_W-1:0]               job_bx_end,
  input  logic [epx3x_pkg::COORD_W-1:0]  job_by_up,
  input  logic [epx3x_pkg::COORD_W-1:0]  job_by_cur,
  input  logic [PIXEL_BITS-1:0]          win [3][3],
  output logic                           job_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [epx3x_pkg::COORD_W-1:0]  out_block_x,
  output logic [epx3x_pkg::COORD_W-1:0]  out_block_y,
  output logic [epx3x_pkg::SUB_W-1:0]    out_sub_row,
  output logic [PIXEL_BITS-1:0]          out_left_pixel,
  output logic [PIXEL_BITS-1:0]          out_middle_pixel,
  output logic [PIXEL_BITS-1:0]          out_right_pixel,
  output logic                           out_last_of_run,
  output logic                           out_frame_done
);

  import epx3x_pkg::*;

  logic [3:0]            pend_r;
  logic [SUB_W-1:0]      sub_r;
  logic                  frame_end_r;
  logic [COL_W-1:0]      bx_mid_r;
  logic [COL_W-1:0]      bx_end_r;
  logic [COORD_W-1:0]    by_up_r;
  logic [COORD_W-1:0]    by_cur_r;
  logic                  out_valid_r;

  logic                  active;
  logic                  out_load;
  logic [3:0]            cur;
  logic [3:0]            rest;
  logic                  last_rows;
  logic                  end_cols;
  logic                  row_done;
  logic                  run_last;
  logic [PIXEL_BITS-1:0] rt [3];
  logic [PIXEL_BITS-1:0] rm [3];
  logic [PIXEL_BITS-1:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
  logic                  db, bf, hd, fh;
  logic [PIXEL_BITS-1:0] px_l, px_m, px_r;

  assign active    = |pend_r;
  assign out_load  = !out_valid_r || !out_stall;
  assign cur       = pend_r & (~pend_r + 4'd1);
  assign rest      = pend_r & ~cur;
  assign last_rows = cur[2] | cur[3];
  assign end_cols  = cur[1] | cur[3];
  assign row_done  = (sub_r == SUB_BOTTOM);
  assign run_last  = row_done && (rest == 4'd0);
  assign job_ready = !active || (out_load && run_last);

  // Neighbourhood: the last source row repeats below itself, the last
  // column repeats to its right.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rt[c] = last_rows ? win[1][c] : win[0][c];
      rm[c] = last_rows ? win[2][c] : win[1][c];
    end
    pa = end_cols ? rt[1] : rt[0];
    pb = end_cols ? rt[2] : rt[1];
    pc = rt[2];
    pd = end_cols ? rm[1] : rm[0];
    pe = end_cols ? rm[2] : rm[1];
    pf = rm[2];
    pg = end_cols ? win[2][1] : win[2][0];
    ph = end_cols ? win[2][2] : win[2][1];
    pi = win[2][2];
  end

  assign db = (pd == pb) && (pd != ph) && (pb != pf);
  assign bf = (pb == pf) && (pb != pd) && (pf != ph);
  assign hd = (ph == pd) && (ph != pf) && (pd != pb);
  assign fh = (pf == ph) && (pf != pb) && (ph != pd);

  always_comb begin
    unique case (sub_r)
      SUB_TOP: begin
        px_l = db ? pd : pe;
        px_m = ((db && pe != pc) || (bf && pe != pa)) ? pb : pe;
        px_r = bf ? pf : pe;
      end
      SUB_CENTRE: begin
        px_l = ((hd && pe != pa) || (db && pe != pg)) ? pd : pe;
        px_m = pe;
        px_r = ((bf && pe != pi) || (fh && pe != pc)) ? pf : pe;
      end
      default: begin
        px_l = hd ? pd : pe;
        px_m = ((fh && pe != pg) || (hd && pe != pi)) ? ph : pe;
        px_r = fh ? pf : pe;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 4'd0;
      sub_r       <= SUB_TOP;
      out_valid_r <= 1'b0;
    end else begin
      if (job_load) begin
        pend_r <= {job_ctl.last_end, job_ctl.last_x, job_ctl.mid_end, job_ctl.mid_x};
        sub_r  <= SUB_TOP;
      end else if (active && out_load) begin
        if (row_done) begin
          pend_r <= rest;
          sub_r  <= SUB_TOP;
        end else begin
          sub_r <= sub_r + SUB_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      frame_end_r <= job_ctl.frame_end;
      bx_mid_r    <= job_bx_mid;
      bx_end_r    <= job_bx_end;
      by_up_r     <= job_by_up;
      by_cur_r    <= job_by_cur;
    end
    if (out_load && active) begin
      out_block_x      <= COORD_W'(end_cols ? bx_end_r : bx_mid_r);
      out_block_y      <= last_rows ? by_cur_r : by_up_r;
      out_sub_row      <= sub_r;
      out_left_pixel   <= px_l;
      out_middle_pixel <= px_m;
      out_right_pixel  <= px_r;
      out_last_of_run  <= run_last;
      out_frame_done   <= run_last && frame_end_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/epx_3x_pixel_art_upscaler_unit.sv -----
// Path: a pixel passes the B stage registers, the window and job registers, and the output
// register. Throughput: one result beat per cycle while out_stall is low; each released block
// is emitted as three rows, top, centre and bottom, and the next pixel waits in the B stage
// until the last row is loaded into the output register. A pixel that releases nothing does not hold up the next.
// Reset (rst_n, synchronous): geometry returns to 640 x 480, the counters clear and the
// pipeline empties. The line memory and the window are not cleared.
module epx_3x_pixel_art_upscaler_unit #(
  parameter int MAX_WIDTH  = epx3x_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = epx3x_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [epx3x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [epx3x_pkg::CFG_W-1:0]     cfg_data,
  // Source pixels
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           in_source_pixel,
  // Output block rows
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [epx3x_pkg::COORD_W-1:0]   out_block_x,
  output logic [epx3x_pkg::COORD_W-1:0]   out_block_y,
  output logic [epx3x_pkg::SUB_W-1:0]     out_sub_row,
  output logic [PIXEL_BITS-1:0]           out_left_pixel,
  output logic [PIXEL_BITS-1:0]           out_middle_pixel,
  output logic [PIXEL_BITS-1:0]           out_right_pixel,
  output logic                            out_last_of_run,
  output logic                            out_frame_done
);

  import epx3x_pkg::*;

  // Column index width, and a width that holds both the register value and MAX_WIDTH.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_CLOG = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (CFG_W > W_CLOG) ? CFG_W : W_CLOG;
  localparam int LINE_W = 2 * PIXEL_BITS;

  // ---------------------------------------------------------------------------
  // Configuration. Writes must arrive only while the block is idle, unenforced;
  // the port is always ready. A write to a known register restarts the frame.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [COL_W-1:0]   col_r;
  logic [COORD_W-1:0] row_r;

  logic [EW-1:0]      w_eff;
  logic [COL_W-1:0]   last_col;
  logic [COORD_W-1:0] last_row_idx;

  assign cfg_ready = 1'b1;

  // Width zero counts as one, and anything beyond the line memory saturates.
  always_comb begin
    if (width_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_r);
    end
    last_col = COL_W'(w_eff - EW'(1));
    if (height_r == '0) begin
      last_row_idx = '0;
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      last_row_idx = COORD_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = COORD_W'(height_r - CFG_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage. The pixel's column selects a line memory entry, read now;
  // the data is there in the following cycle, in the B stage.
  // ---------------------------------------------------------------------------
  logic               in_accept;
  logic [COL_W-1:0]   acc_col;
  logic [COORD_W-1:0] acc_row;
  logic               acc_row_end;
  logic               acc_last_row;

  logic                  b_valid_r;
  logic [PIXEL_BITS-1:0] b_px_r;
  logic [COL_W-1:0]      b_col_r;
  logic [COORD_W-1:0]    b_row_r;
  logic                  b_row_end_r;
  logic                  b_last_row_r;
  logic                  fwd_r;
  logic [LINE_W-1:0]     fwd_data_r;

  logic                  job_ready;
  logic                  b_move;

  assign b_move    = b_valid_r && job_ready;
  assign in_stall  = b_valid_r && !job_ready;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    acc_col      = (col_r > last_col) ? '0 : col_r;
    acc_row      = (row_r > last_row_idx) ? '0 : row_r;
    acc_row_end  = (acc_col == last_col);
    acc_last_row = (acc_row == last_row_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CFG_W'(640);
      height_r  <= CFG_W'(480);
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (in_accept) begin
        if (acc_row_end) begin
          col_r <= '0;
          row_r <= acc_last_row ? '0 : acc_row + COORD_W'(1);
        end else begin
          col_r <= acc_col + COL_W'(1);
          row_r <= acc_row;
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_r <= cfg_data;
            col_r   <= '0;
            row_r   <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_r <= cfg_data;
            col_r    <= '0;
            row_r    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // B stage: line memory read-modify-write and window shift.
  // Each memory entry holds the two rows above the current one, {older, newer}.
  // The pixel shifts them: older takes newer and newer takes the pixel. On the
  // first row both take the pixel, which clamps the top edge.
  // When the image is one column wide, consecutive pixels hit the same entry;
  // a read issued in the cycle that entry is written sees stale data, so the
  // written word is captured and forwarded in its place.
  // ---------------------------------------------------------------------------
  logic [LINE_W-1:0]     rd_data;
  logic [LINE_W-1:0]     line_word;
  logic [PIXEL_BITS-1:0] up_px;
  logic [PIXEL_BITS-1:0] mid_px;
  logic [LINE_W-1:0]     wr_data;

  assign line_word = fwd_r ? fwd_data_r : rd_data;
  assign up_px     = (b_row_r == '0) ? b_px_r : line_word[LINE_W-1:PIXEL_BITS];
  assign mid_px    = (b_row_r == '0) ? b_px_r : line_word[PIXEL_BITS-1:0];
  assign wr_data   = {mid_px, b_px_r};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_px_r       <= in_source_pixel;
      b_col_r      <= acc_col;
      b_row_r      <= acc_row;
      b_row_end_r  <= acc_row_end;
      b_last_row_r <= acc_last_row;
      fwd_r        <= b_move && (acc_col == b_col_r);
      fwd_data_r   <= wr_data;
    end
  end

  epx3x_line_mem #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (acc_col),
    .rd_data (rd_data),
    .wr_en   (b_move),
    .wr_addr (b_col_r),
    .wr_data (wr_data)
  );

  // The window holds rows above, centre and current by three columns. At the
  // start of a row every column takes the new value, which clamps the left
  // edge. It changes only when the emitter takes a new job, so the emitter
  // reads it directly for the whole of its job.
  logic [PIXEL_BITS-1:0] window_r [3][3];
  logic [PIXEL_BITS-1:0] new_col [3];

  assign new_col[0] = up_px;
  assign new_col[1] = mid_px;
  assign new_col[2] = b_px_r;

  always_ff @(posedge clk) begin
    if (b_move) begin
      for (int r = 0; r < 3; r++) begin
        if (b_col_r == '0) begin
          window_r[r][0] <= new_col[r];
          window_r[r][1] <= new_col[r];
        end else begin
          window_r[r][0] <= window_r[r][1];
          window_r[r][1] <= window_r[r][2];
        end
        window_r[r][2] <= new_col[r];
      end
    end
  end

  // A pixel releases the block left of and above it, the block at the end of
  // the row above when it closes a row, and on the last row the blocks of its
  // own row, whose lower neighbours are clamped.
  job_ctl_t job_ctl;

  always_comb begin
    job_ctl.mid_x     = (b_row_r != '0) && (b_col_r != '0);
    job_ctl.mid_end   = (b_row_r != '0) && b_row_end_r;
    job_ctl.last_x    = b_last_row_r && (b_col_r != '0);
    job_ctl.last_end  = b_last_row_r && b_row_end_r;
    job_ctl.frame_end = b_last_row_r && b_row_end_r;
  end

  epx3x_emit #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_load         (b_move),
    .job_ctl          (job_ctl),
    .job_bx_mid       (b_col_r - COL_W'(1)),
    .job_bx_end       (last_col),
    .job_by_up        (b_row_r - COORD_W'(1)),
    .job_by_cur       (b_row_r),
    .win              (window_r),
    .job_ready        (job_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_x      (out_block_x),
    .out_block_y      (out_block_y),
    .out_sub_row      (out_sub_row),
    .out_left_pixel   (out_left_pixel),
    .out_middle_pixel (out_middle_pixel),
    .out_right_pixel  (out_right_pixel),
    .out_last_of_run  (out_last_of_run),
    .out_frame_done   (out_frame_done)
  );

endmodule
